[sv/dedw_pkg.sv]
// Shared constants, codes and the month table for the elapsed-day window block.
// Used by dedw_day_number and date_elapsed_days_window_unit; depends on nothing.
package dedw_pkg;

  localparam int YEAR_W    = 12;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int WIN_W     = 10;
  localparam int ELAPSED_W = 22;
  // Width of a biased absolute day number; the common offset cancels in the difference.
  localparam int DN_W      = 21;
  localparam int CUM_W     = 9;
  localparam int ORDER_W   = 2;

  localparam int YEAR_BIAS    = 399;
  localparam int DAYS_COMMON  = 365;
  // floor(n / 25) == (n * RECIP_25) >> RECIP_SHIFT for every n below 2048.
  localparam int RECIP_25     = 2622;
  localparam int RECIP_SHIFT  = 16;

  localparam logic [WIN_W-1:0] WIN_LOW_RESET  = WIN_W'(14);
  localparam logic [WIN_W-1:0] WIN_HIGH_RESET = WIN_W'(28);

  localparam logic [ORDER_W-1:0] ORD_EARLIER = 2'd0;
  localparam logic [ORDER_W-1:0] ORD_EQUAL   = 2'd1;
  localparam logic [ORDER_W-1:0] ORD_LATER   = 2'd2;

  localparam int ADDR_W = 3;
  localparam logic [0:0] REG_WINDOW_LOW  = 1'b0;
  localparam logic [0:0] REG_WINDOW_HIGH = 1'b1;

  // Days before the first of the month; month zero adds nothing, months past
  // December saturate at a whole year.
  function automatic logic [CUM_W-1:0] cum_days(input logic leap,
                                                input logic [MONTH_W-1:0] month);
    logic [CUM_W-1:0] base;
    logic             after_feb;
    base      = '0;
    after_feb = 1'b1;
    case (month)
      4'd0:    begin base = 9'd0;   after_feb = 1'b0; end
      4'd1:    begin base = 9'd0;   after_feb = 1'b0; end
      4'd2:    begin base = 9'd31;  after_feb = 1'b0; end
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd365;
    endcase
    return base + CUM_W'(leap && after_feb);
  endfunction

endpackage

[sv/dedw_day_number.sv]
// Three-stage pipeline that turns a Gregorian date into an absolute day number.
// Depends on dedw_pkg for widths, the reciprocal constant and the month table.
module dedw_day_number import dedw_pkg::*; (
  input  logic               clk,
  input  logic [YEAR_W-1:0]  year,
  input  logic [MONTH_W-1:0] month,
  input  logic [DAY_W-1:0]   day,
  output logic [DN_W-1:0]    day_num
);

  // Stage 1: bias the year and start both divisions by 25 as multiplies.
  logic [YEAR_W:0]     a_comb;
  logic [YEAR_W-2:0]   q4_comb;
  logic [YEAR_W:0]     s1_a;
  logic [YEAR_W-2:0]   s1_q4;
  logic [YEAR_W-3:0]   s1_yq;
  logic [22:0]         s1_prod_a;
  logic [21:0]         s1_prod_y;
  logic [1:0]          s1_ylow;
  logic [MONTH_W-1:0]  s1_month;
  logic [DAY_W-1:0]    s1_day;

  assign a_comb  = (YEAR_W+1)'(year) + (YEAR_W+1)'(YEAR_BIAS);
  assign q4_comb = a_comb[YEAR_W:2];

  always_ff @(posedge clk) begin
    s1_a      <= a_comb;
    s1_q4     <= q4_comb;
    s1_yq     <= year[YEAR_W-1:2];
    s1_prod_a <= 23'(q4_comb) * 23'(RECIP_25);
    s1_prod_y <= 22'(year[YEAR_W-1:2]) * 22'(RECIP_25);
    s1_ylow   <= year[1:0];
    s1_month  <= month;
    s1_day    <= day;
  end

  // Stage 2: whole-year day count and the leap flag.
  logic [5:0]          q100;
  logic [5:0]          yq25;
  logic [YEAR_W-3:0]   rem25;
  logic                leap_comb;
  logic [DN_W-1:0]     year_days_comb;
  logic [DN_W-1:0]     s2_year_days;
  logic                s2_leap;
  logic [MONTH_W-1:0]  s2_month;
  logic [DAY_W-1:0]    s2_day;

  assign q100  = s1_prod_a[RECIP_SHIFT+5:RECIP_SHIFT];
  assign yq25  = s1_prod_y[RECIP_SHIFT+5:RECIP_SHIFT];
  assign rem25 = s1_yq - ((YEAR_W-2)'(yq25) * (YEAR_W-2)'(25));
  // Divisible by 4, and either not by 100 or also by 400.
  assign leap_comb = (s1_ylow == 2'd0) && ((rem25 != '0) || (yq25[1:0] == 2'd0));
  assign year_days_comb = DN_W'(s1_a) * DN_W'(DAYS_COMMON) + DN_W'(s1_q4)
                        - DN_W'(q100) + DN_W'(q100[5:2]);

  always_ff @(posedge clk) begin
    s2_year_days <= year_days_comb;
    s2_leap      <= leap_comb;
    s2_month     <= s1_month;
    s2_day       <= s1_day;
  end

  // Stage 3: add the month offset and the day of month.
  always_ff @(posedge clk) begin
    day_num <= s2_year_days + DN_W'(cum_days(s2_leap, s2_month)) + DN_W'(s2_day);
  end

endmodule

[sv/date_elapsed_days_window_unit.sv]
// Elapsed days between an event date and a reference date, with window flag and order.
// The result strobe (done) accompanies the registered result fields.
// Throughput: one request per cycle; busy is never raised and results cannot be stalled.
// Five register stages set the latency: three day-number stages, a subtract, a compare.
// Reset (rst, synchronous) clears the valid bits and sets the window to 14 through 28.
module date_elapsed_days_window_unit import dedw_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  // Request side.
  input  logic                        start,
  output logic                        busy,
  input  logic [YEAR_W-1:0]           event_year,
  input  logic [MONTH_W-1:0]          event_month,
  input  logic [DAY_W-1:0]            event_day,
  input  logic [YEAR_W-1:0]           today_year,
  input  logic [MONTH_W-1:0]          today_month,
  input  logic [DAY_W-1:0]            today_day,
  // Result side.
  output logic                        done,
  output logic signed [ELAPSED_W-1:0] elapsed_days,
  output logic                        in_window,
  output logic [ORDER_W-1:0]          date_order,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ADDR_W-1:0]           paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  // The pipeline takes a request every cycle and never backs up.
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Window registers. Writes land on the access phase; only bit 2 of the
  // address selects a register.
  logic [WIN_W-1:0] window_low;
  logic [WIN_W-1:0] window_high;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_low  <= WIN_LOW_RESET;
      window_high <= WIN_HIGH_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2:2])
        REG_WINDOW_LOW:  window_low  <= pwdata[WIN_W-1:0];
        REG_WINDOW_HIGH: window_high <= pwdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2:2])
      REG_WINDOW_LOW:  prdata = 32'(window_low);
      REG_WINDOW_HIGH: prdata = 32'(window_high);
      default:         prdata = '0;
    endcase
  end

  // The order compares the raw fields year, then month, then day, so it is
  // settled at the input and simply rides along with the request.
  logic [ORDER_W-1:0] order_comb;

  always_comb begin
    if (event_year != today_year) begin
      order_comb = (event_year > today_year) ? ORD_LATER : ORD_EARLIER;
    end else if (event_month != today_month) begin
      order_comb = (event_month > today_month) ? ORD_LATER : ORD_EARLIER;
    end else if (event_day != today_day) begin
      order_comb = (event_day > today_day) ? ORD_LATER : ORD_EARLIER;
    end else begin
      order_comb = ORD_EQUAL;
    end
  end

  // Stages 1 to 3: both dates go through their own day-number pipeline.
  logic [DN_W-1:0] event_num;
  logic [DN_W-1:0] today_num;

  dedw_day_number u_event_num (
    .clk     (clk),
    .year    (event_year),
    .month   (event_month),
    .day     (event_day),
    .day_num (event_num)
  );

  dedw_day_number u_today_num (
    .clk     (clk),
    .year    (today_year),
    .month   (today_month),
    .day     (today_day),
    .day_num (today_num)
  );

  // Valid bits and the order code follow the data through the five stages.
  logic [4:0]         valid;
  logic [ORDER_W-1:0] order_pipe [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[3:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    order_pipe[0] <= order_comb;
    order_pipe[1] <= order_pipe[0];
    order_pipe[2] <= order_pipe[1];
    order_pipe[3] <= order_pipe[2];
  end

  // Stage 4: signed difference. Both day numbers share the same offset, so
  // a plain wrap-around subtract in the output width is exact.
  logic signed [ELAPSED_W-1:0] diff;

  always_ff @(posedge clk) begin
    diff <= ELAPSED_W'(today_num) - ELAPSED_W'(event_num);
  end

  // Stage 5: window check and the output register. A negative count is
  // never inside the window.
  logic inside_comb;
  assign inside_comb = !diff[ELAPSED_W-1]
                    && (diff[ELAPSED_W-2:0] >= (ELAPSED_W-1)'(window_low))
                    && (diff[ELAPSED_W-2:0] <= (ELAPSED_W-1)'(window_high));

  always_ff @(posedge clk) begin
    elapsed_days <= diff;
    in_window    <= inside_comb;
    date_order   <= order_pipe[3];
  end

  assign done = valid[4];

  // An accepted request always produces its result strobe after passing through the pipeline.
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##5 done)
    else $error("result strobe missing five cycles after a request");

  // Equal dates must give a zero day count.
  a_equal_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (date_order == ORD_EQUAL)) |-> (elapsed_days == '0))
    else $error("equal dates with a nonzero day count");

  // The window flag never accompanies a negative count.
  a_window_sign: assert property (@(posedge clk) disable iff (rst)
    (done && in_window) |-> !elapsed_days[ELAPSED_W-1])
    else $error("window flag set for a negative day count");

  // The order code is one of its three values on every result.
  a_order_code: assert property (@(posedge clk) disable iff (rst)
    done |-> ((date_order == ORD_EARLIER) || (date_order == ORD_EQUAL)
              || (date_order == ORD_LATER)))
    else $error("undefined order code on a result");

endmodule

[verif/date_elapsed_days_window_unit_tb.sv]
// Self-checking bench for date_elapsed_days_window_unit: elapsed days, window flag and date order.
// Needs dedw_pkg and the block's RTL; a clocked driver and monitor check every result in order.
module date_elapsed_days_window_unit_tb;
  import dedw_pkg::*;

  localparam int BIAS_YEARS  = 399;
  localparam int DAYS_400Y   = 146097;
  localparam int STALL_LIMIT = 200;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // One request: the event date, the reference date and the idle cycles that precede it.
  typedef struct packed {
    date_t      ev;
    date_t      td;
    logic [2:0] gap;
  } date_pair_t;

  typedef struct packed {
    logic signed [ELAPSED_W-1:0] days;
    logic                        in_win;
    logic [ORDER_W-1:0]          order;
  } window_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                start = 1'b0;
  logic                busy;
  logic [YEAR_W-1:0]   event_year  = '0;
  logic [MONTH_W-1:0]  event_month = '0;
  logic [DAY_W-1:0]    event_day   = '0;
  logic [YEAR_W-1:0]   today_year  = '0;
  logic [MONTH_W-1:0]  today_month = '0;
  logic [DAY_W-1:0]    today_day   = '0;

  logic                        done;
  logic signed [ELAPSED_W-1:0] elapsed_days;
  logic                        in_window;
  logic [ORDER_W-1:0]          date_order;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Bench copy of the two window registers, starting from their reset values.
  logic [WIN_W-1:0] win_lo = WIN_W'(14);
  logic [WIN_W-1:0] win_hi = WIN_W'(28);

  date_pair_t     date_pair_q[$];
  window_result_t expected_results_q[$];
  date_pair_t     cur_pair;

  int  queued_cnt   = 0;
  int  accepted_cnt = 0;
  int  checked_cnt  = 0;
  int  err_cnt      = 0;
  int  idle_wait    = 0;
  int  stall_cycles = 0;
  int  gap_mode     = 1;
  bit  req_taken    = 1'b0;

  date_elapsed_days_window_unit i_dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .event_year(event_year), .event_month(event_month), .event_day(event_day),
    .today_year(today_year), .today_month(today_month), .today_day(today_day),
    .done(done), .elapsed_days(elapsed_days), .in_window(in_window), .date_order(date_order),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Days in the months before month m; month zero adds nothing and anything past
  // December counts as the whole year.
  function automatic int month_offset(input bit leap, input int unsigned m);
    int base;
    case (m)
      0, 1:    base = 0;
      2:       base = 31;
      3:       base = 59;
      4:       base = 90;
      5:       base = 120;
      6:       base = 151;
      7:       base = 181;
      8:       base = 212;
      9:       base = 243;
      10:      base = 273;
      11:      base = 304;
      12:      base = 334;
      default: base = 365;
    endcase
    return base + ((leap && m >= 3) ? 1 : 0);
  endfunction

  // Absolute day number; the year bias keeps every division on a non-negative value.
  function automatic longint day_index(input date_t d);
    longint a;
    a = longint'(d.year) + BIAS_YEARS;
    return 365 * a + a / 4 - a / 100 + a / 400 - DAYS_400Y
           + month_offset(leap_year(d.year), d.month) + longint'(d.day);
  endfunction

  // Order compares the raw fields, so invalid dates may disagree with the day count.
  function automatic logic [ORDER_W-1:0] order_code(input date_t ev, input date_t td);
    if (ev.year != td.year)   return (ev.year > td.year) ? ORD_LATER : ORD_EARLIER;
    if (ev.month != td.month) return (ev.month > td.month) ? ORD_LATER : ORD_EARLIER;
    if (ev.day != td.day)     return (ev.day > td.day) ? ORD_LATER : ORD_EARLIER;
    return ORD_EQUAL;
  endfunction

  function automatic window_result_t predict_window_result(input date_t ev, input date_t td);
    window_result_t r;
    longint         diff;
    diff     = day_index(td) - day_index(ev);
    r.days   = diff[ELAPSED_W-1:0];
    r.in_win = (diff >= longint'(win_lo)) && (diff <= longint'(win_hi));
    r.order  = order_code(ev, td);
    return r;
  endfunction

  function automatic date_t mk_date(input int unsigned y, input int unsigned m,
                                    input int unsigned d);
    date_t r;
    r.year  = YEAR_W'(y);
    r.month = MONTH_W'(m);
    r.day   = DAY_W'(d);
    return r;
  endfunction

  function automatic int unsigned rand_day(input int unsigned y, input int unsigned m);
    bit l;
    l = leap_year(y);
    return $urandom_range(1, month_offset(l, m + 1) - month_offset(l, m));
  endfunction

  function automatic date_t rand_valid_date(input int unsigned y);
    int unsigned m;
    m = $urandom_range(1, 12);
    return mk_date(y, m, rand_day(y, m));
  endfunction

  // Mode 0 sends back to back, mode 1 draws a random idle gap, mode 2 mostly runs in bursts.
  function automatic logic [2:0] draw_gap();
    if (gap_mode == 0) return 3'd0;
    if (gap_mode == 2 && $urandom_range(0, 9) < 7) return 3'd0;
    return 3'($urandom_range(0, 7));
  endfunction

  task automatic push_pair(input date_t ev, input date_t td);
    date_pair_t p;
    p.ev  = ev;
    p.td  = td;
    p.gap = draw_gap();
    date_pair_q.push_back(p);
    queued_cnt++;
  endtask

  // Returns at a falling edge once every queued request has been taken and answered.
  task automatic wait_drained();
    @(negedge clk);
    while (accepted_cnt != queued_cnt || checked_cnt != accepted_cnt) @(negedge clk);
  endtask

  task automatic apb_write(input logic [0:0] idx, input logic [WIN_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * idx);
    // Upper data bits are junk; the register keeps only its low ten bits.
    pwdata  <= {22'($urandom), val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_WINDOW_LOW) win_lo = val;
    else win_hi = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [0:0] idx, input logic [WIN_W-1:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(4 * idx);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== 32'(want)) begin
      $error("prdata: expected %0d, actual %0d", want, prdata);
      err_cnt++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Only called with the block drained, so no request sees a half-written window.
  task automatic set_window(input logic [WIN_W-1:0] lo, input logic [WIN_W-1:0] hi);
    apb_write(REG_WINDOW_LOW, lo);
    apb_write(REG_WINDOW_HIGH, hi);
    apb_read_check(REG_WINDOW_LOW, lo);
    apb_read_check(REG_WINDOW_HIGH, hi);
    @(posedge clk);
  endtask

  // Mostly close date pairs so the window flag toggles, plus far pairs and raw noise.
  task automatic run_random(input int n);
    date_t       ev;
    date_t       td;
    int unsigned cat;
    int unsigned y;
    int unsigned m;
    for (int i = 0; i < n; i++) begin
      cat = $urandom_range(0, 99);
      y   = $urandom_range(1, 4095);
      if (cat < 25) begin
        m  = $urandom_range(1, 12);
        ev = mk_date(y, m, rand_day(y, m));
        td = mk_date(y, m, rand_day(y, m));
      end else if (cat < 45) begin
        ev = rand_valid_date(y);
        td = rand_valid_date(y);
      end else if (cat < 60) begin
        y  = $urandom_range(1, 4094);
        ev = rand_valid_date(y);
        td = rand_valid_date(y + 1);
        if ($urandom_range(0, 3) == 0) begin
          ev = td;
          td = rand_valid_date(y);
        end
      end else if (cat < 80) begin
        ev = rand_valid_date(y);
        td = rand_valid_date($urandom_range(1, 4095));
      end else begin
        ev = date_t'($urandom);
        td = date_t'($urandom);
      end
      push_pair(ev, td);
    end
  endtask

  // Driver: presents the next request at the falling edge once its idle gap has passed.
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !req_taken) begin
        // Request not taken yet; hold it.
      end else if (date_pair_q.size() != 0 && idle_wait >= date_pair_q[0].gap) begin
        cur_pair = date_pair_q.pop_front();
        event_year  <= cur_pair.ev.year;
        event_month <= cur_pair.ev.month;
        event_day   <= cur_pair.ev.day;
        today_year  <= cur_pair.td.year;
        today_month <= cur_pair.td.month;
        today_day   <= cur_pair.td.day;
        start       <= 1'b1;
        idle_wait = 0;
      end else begin
        start <= 1'b0;
        if (date_pair_q.size() != 0) idle_wait++;
      end
      req_taken = 1'b0;
    end
  end

  // Monitor: predicts each accepted request and checks each strobed result in order.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        req_taken = 1'b1;
        accepted_cnt++;
        expected_results_q.push_back(predict_window_result(
          mk_date(event_year, event_month, event_day),
          mk_date(today_year, today_month, today_day)));
      end
      if (done) begin
        if (expected_results_q.size() == 0) begin
          $error("done strobe with no request outstanding");
          err_cnt++;
        end else begin
          window_result_t w;
          w = expected_results_q.pop_front();
          checked_cnt++;
          if (elapsed_days !== w.days) begin
            $error("elapsed_days: expected %0d, actual %0d", w.days, elapsed_days);
            err_cnt++;
          end
          if (in_window !== w.in_win) begin
            $error("in_window: expected %0d, actual %0d", w.in_win, in_window);
            err_cnt++;
          end
          if (date_order !== w.order) begin
            $error("date_order: expected %0d, actual %0d", w.order, date_order);
            err_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: the run is stuck if nothing is accepted or answered for too long.
  always @(posedge clk) begin
    if ((start && !busy) || done) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("date_elapsed_days_window_unit verification failed");
      $finish;
    end
  end

  initial begin
    logic [WIN_W-1:0] lo;
    logic [WIN_W-1:0] hi;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset window values must read back before anything is written.
    apb_read_check(REG_WINDOW_LOW, WIN_W'(14));
    apb_read_check(REG_WINDOW_HIGH, WIN_W'(28));
    @(posedge clk);

    // Directed requests under the reset window of 14 to 28.
    gap_mode = 1;
    push_pair(mk_date(1, 1, 1), mk_date(1, 1, 1));
    push_pair(mk_date(1, 1, 1), mk_date(4095, 12, 31));
    push_pair(mk_date(4095, 12, 31), mk_date(1, 1, 1));
    push_pair(mk_date(0, 2, 29), mk_date(1, 1, 1));       // year zero is a leap year
    push_pair(mk_date(0, 0, 0), mk_date(0, 0, 0));
    push_pair(mk_date(4095, 15, 31), mk_date(4095, 15, 31));
    push_pair(mk_date(2023, 0, 5), mk_date(2023, 13, 5));  // month zero against month 13
    push_pair(mk_date(2024, 14, 1), mk_date(2025, 1, 1));  // saturated month lands on next year
    push_pair(mk_date(2024, 2, 31), mk_date(2024, 3, 1));  // day past month end
    push_pair(mk_date(2024, 3, 0), mk_date(2024, 2, 29));  // day zero
    push_pair(mk_date(2000, 2, 28), mk_date(2000, 3, 1));
    push_pair(mk_date(1900, 2, 28), mk_date(1900, 3, 1));
    push_pair(mk_date(2100, 2, 28), mk_date(2100, 3, 1));
    push_pair(mk_date(2024, 1, 1), mk_date(2024, 1, 14));  // just below the window
    push_pair(mk_date(2024, 1, 1), mk_date(2024, 1, 15));  // window low edge
    push_pair(mk_date(2024, 1, 1), mk_date(2024, 1, 29));  // window high edge
    push_pair(mk_date(2024, 1, 1), mk_date(2024, 1, 30));  // just above the window
    push_pair(mk_date(2024, 1, 20), mk_date(2024, 1, 10)); // event after reference
    push_pair(mk_date(2023, 12, 31), mk_date(2024, 1, 1));
    push_pair(mk_date(2024, 5, 9), mk_date(2024, 5, 9));
    wait_drained();

    // Each phase changes the window only after the previous one has fully drained.
    set_window(WIN_W'(0), WIN_W'(0));
    gap_mode = 0;
    run_random(200);
    wait_drained();

    set_window(WIN_W'(1023), WIN_W'(1023));
    gap_mode = 1;
    run_random(150);
    wait_drained();

    set_window(WIN_W'(0), WIN_W'(1023));
    gap_mode = 2;
    run_random(250);
    wait_drained();

    // Low above high leaves the window empty.
    set_window(WIN_W'(600), WIN_W'(100));
    gap_mode = 1;
    run_random(200);
    wait_drained();

    for (int k = 0; k < 3; k++) begin
      lo = WIN_W'($urandom_range(0, 300));
      hi = WIN_W'($urandom_range(0, 1023));
      set_window(lo, hi);
      gap_mode = k % 3;
      run_random(150);
      wait_drained();
    end

    set_window(WIN_W'(14), WIN_W'(28));
    gap_mode = 2;
    run_random(250);
    wait_drained();

    // Let any stray strobe show up before the verdict.
    repeat (12) @(posedge clk);
    if (expected_results_q.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("date_elapsed_days_window_unit verification clean");
    end else begin
      $display("date_elapsed_days_window_unit verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
sv/dedw_pkg.sv
sv/dedw_day_number.sv
sv/date_elapsed_days_window_unit.sv
verif/date_elapsed_days_window_unit_tb.sv
